FILE: src/line_sensor_pd_steering_defines.svh
`ifndef LINE_SENSOR_PD_STEERING_DEFINES_SVH
`define LINE_SENSOR_PD_STEERING_DEFINES_SVH

// assertion helpers, clocked on clock and quiet while reset is high

// cond holds in a cycle, prop holds in the same cycle
`define LSPD_ASSERT_HOLDS(label, cond, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) \
      else $error(msg);

// cond holds in a cycle, prop holds in the next one
`define LSPD_ASSERT_NEXT(label, cond, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error(msg);

`endif

FILE: src/lspd_pkg.sv
package lspd_pkg;

   localparam int SENSOR_COUNT = 5;
   localparam int FIELD_W = 12;
   localparam int CFG_DATA_W = 12;
   localparam int REG_INDEX_W = 3;
   localparam int GAIN_W = 8;
   localparam int SPEED_W = 8;
   localparam int ERROR_W = 4;

   localparam int SAMPLE_WIDTH_DEFAULT = 12;
   localparam int QUEUE_DEPTH_DEFAULT = 2;

   localparam int BASE_DUTY = 100;
   localparam int CHANGE_LIMIT = 100;
   localparam int THRESHOLD_RESET = 2048;
   localparam int GAIN_P_RESET = 40;
   localparam int GAIN_D_RESET = 40;

   // register indexes
   localparam logic [REG_INDEX_W-1:0] REG_THRESHOLD_0 = 3'd0;
   localparam logic [REG_INDEX_W-1:0] REG_THRESHOLD_1 = 3'd1;
   localparam logic [REG_INDEX_W-1:0] REG_THRESHOLD_2 = 3'd2;
   localparam logic [REG_INDEX_W-1:0] REG_THRESHOLD_3 = 3'd3;
   localparam logic [REG_INDEX_W-1:0] REG_THRESHOLD_4 = 3'd4;
   localparam logic [REG_INDEX_W-1:0] REG_WHITE_BG = 3'd5;
   localparam logic [REG_INDEX_W-1:0] REG_GAIN_P = 3'd6;
   localparam logic [REG_INDEX_W-1:0] REG_GAIN_D = 3'd7;

   typedef logic [SENSOR_COUNT-1:0] mask_type;
   typedef logic signed [ERROR_W-1:0] error_type;
   typedef logic [SPEED_W-1:0] speed_type;

   typedef struct packed {
      logic write_en;
      logic [REG_INDEX_W-1:0] index;
      logic [CFG_DATA_W-1:0] wdata;
   } csr_write_type;

   typedef struct packed {
      logic valid;
      mask_type mask;
   } queue_entry_type;

endpackage

FILE: src/line_sensor_pd_steering.sv
// line sensor pd steering: one item is a set of five reflectance samples; each is
// compared with its threshold register to form the on-line mask, the mask is decoded to a
// position error (-4..4, or +/-5 when the line is lost), and a pd term around a base duty
// of 100 sets the two motor speeds (0..200). throughput is one item per clock while
// req_stall is low; an accepted item is written into the queue, then loaded into the
// output register. the only loop-carried value is the previous error, which lives in
// the back end next to the pd arithmetic, so the front end never waits on it. req_stall
// rises only when the queue between front and back holds QUEUE_DEPTH items, which
// happens only after rsp_stall held the output register. configuration is written
// through csr_* and is meant to change only while no item is in flight.
module line_sensor_pd_steering #(
   parameter int SAMPLE_WIDTH = lspd_pkg::SAMPLE_WIDTH_DEFAULT,
   parameter int QUEUE_DEPTH = lspd_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic clock,
   input  logic reset,

   // configuration write port
   input  logic csr_write_en,
   input  logic [lspd_pkg::REG_INDEX_W-1:0] csr_index,
   input  logic [lspd_pkg::CFG_DATA_W-1:0] csr_wdata,

   // sample items
   input  logic req_valid,
   output logic req_stall,
   input  logic [SAMPLE_WIDTH-1:0] req_sample_0,
   input  logic [SAMPLE_WIDTH-1:0] req_sample_1,
   input  logic [SAMPLE_WIDTH-1:0] req_sample_2,
   input  logic [SAMPLE_WIDTH-1:0] req_sample_3,
   input  logic [SAMPLE_WIDTH-1:0] req_sample_4,

   // steering result items
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic [lspd_pkg::SPEED_W-1:0] rsp_left_speed,
   output logic [lspd_pkg::SPEED_W-1:0] rsp_right_speed,
   output logic signed [lspd_pkg::ERROR_W-1:0] rsp_line_error,
   output logic [lspd_pkg::SENSOR_COUNT-1:0] rsp_on_line_mask
);
   import lspd_pkg::*;

   csr_write_type csr;
   queue_entry_type push;
   queue_entry_type head;
   logic queue_full;
   logic pop;
   logic [SAMPLE_WIDTH-1:0] sample [SENSOR_COUNT];

   // one write bundle fans out to both ends, each decodes its own registers
   assign csr.write_en = csr_write_en;
   assign csr.index = csr_index;
   assign csr.wdata = csr_wdata;

   // sensor 0 is leftmost, sensor 4 rightmost
   assign sample[0] = req_sample_0;
   assign sample[1] = req_sample_1;
   assign sample[2] = req_sample_2;
   assign sample[3] = req_sample_3;
   assign sample[4] = req_sample_4;

   // an item is taken whenever the queue has room
   assign req_stall = queue_full;

   // front end: threshold compare, produces the on-line mask
   lspd_front #(
      .SAMPLE_WIDTH(SAMPLE_WIDTH)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .csr(csr),
      .req_valid(req_valid),
      .sample(sample),
      .push(push)
   );

   // short mask queue decoupling the two ends
   lspd_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock(clock),
      .reset(reset),
      .push(push),
      .full(queue_full),
      .pop(pop),
      .head(head)
   );

   // back end: error decode, pd law, output register
   lspd_back u_back (
      .clock(clock),
      .reset(reset),
      .csr(csr),
      .head(head),
      .pop(pop),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_left_speed(rsp_left_speed),
      .rsp_right_speed(rsp_right_speed),
      .rsp_line_error(rsp_line_error),
      .rsp_on_line_mask(rsp_on_line_mask)
   );

endmodule

FILE: src/lspd_front.sv
module lspd_front #(
   parameter int SAMPLE_WIDTH = lspd_pkg::SAMPLE_WIDTH_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   input  lspd_pkg::csr_write_type csr,
   input  logic req_valid,
   input  logic [SAMPLE_WIDTH-1:0] sample [lspd_pkg::SENSOR_COUNT],
   output lspd_pkg::queue_entry_type push
);
   import lspd_pkg::*;

   // compare width: register field width, trimmed to the sample width
   localparam int CMP_W = (SAMPLE_WIDTH < FIELD_W) ? SAMPLE_WIDTH : FIELD_W;
   localparam logic [CMP_W-1:0] THR_RESET = CMP_W'(THRESHOLD_RESET);

   logic [CMP_W-1:0] threshold_ff [SENSOR_COUNT];
   logic white_bg_ff;
   mask_type mask;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SENSOR_COUNT; i++) begin
            threshold_ff[i] <= THR_RESET;
         end
         white_bg_ff <= 1'b0;
      end else if (csr.write_en) begin
         case (csr.index)
            REG_THRESHOLD_0: threshold_ff[0] <= csr.wdata[CMP_W-1:0];
            REG_THRESHOLD_1: threshold_ff[1] <= csr.wdata[CMP_W-1:0];
            REG_THRESHOLD_2: threshold_ff[2] <= csr.wdata[CMP_W-1:0];
            REG_THRESHOLD_3: threshold_ff[3] <= csr.wdata[CMP_W-1:0];
            REG_THRESHOLD_4: threshold_ff[4] <= csr.wdata[CMP_W-1:0];
            REG_WHITE_BG:    white_bg_ff <= csr.wdata[0];
            default: ;
         endcase
      end
   end

   // equal to threshold counts as on line in both modes
   always_comb begin
      for (int i = 0; i < SENSOR_COUNT; i++) begin
         if (white_bg_ff) begin
            mask[i] = (sample[i][CMP_W-1:0] <= threshold_ff[i]);
         end else begin
            mask[i] = (sample[i][CMP_W-1:0] >= threshold_ff[i]);
         end
      end
   end

   assign push.valid = req_valid;
   assign push.mask = mask;

endmodule

FILE: src/lspd_queue.sv
module lspd_queue #(
   parameter int DEPTH = lspd_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   input  lspd_pkg::queue_entry_type push,
   output logic full,
   input  logic pop,
   output lspd_pkg::queue_entry_type head
);
   import lspd_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);

   mask_type mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic do_push;
   logic do_pop;

   assign full = (count_ff == FULL_COUNT);
   assign do_push = push.valid && !full;
   assign do_pop = pop && (count_ff != '0);

   assign head.valid = (count_ff != '0);
   assign head.mask = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push.mask;
      end
   end

endmodule

FILE: src/lspd_back.sv
`include "line_sensor_pd_steering_defines.svh"

module lspd_back (
   input  logic clock,
   input  logic reset,
   input  lspd_pkg::csr_write_type csr,
   input  lspd_pkg::queue_entry_type head,
   output logic pop,
   output logic rsp_valid,
   input  logic rsp_stall,
   output lspd_pkg::speed_type rsp_left_speed,
   output lspd_pkg::speed_type rsp_right_speed,
   output lspd_pkg::error_type rsp_line_error,
   output lspd_pkg::mask_type rsp_on_line_mask
);
   import lspd_pkg::*;

   localparam int CHG_W = 16;
   localparam int SUM_W = SPEED_W + 1;
   localparam logic signed [CHG_W-1:0] LIMIT_HI = CHG_W'(CHANGE_LIMIT);
   localparam logic signed [CHG_W-1:0] LIMIT_LO = CHG_W'(-CHANGE_LIMIT);
   localparam logic signed [SUM_W-1:0] BASE_S = SUM_W'(BASE_DUTY);
   localparam speed_type NEUTRAL_DUTY = SPEED_W'(BASE_DUTY);
   localparam error_type ERR_LOST_POS = 4'sd5;
   localparam error_type ERR_LOST_NEG = -4'sd5;

   logic [GAIN_W-1:0] gain_p_ff;
   logic [GAIN_W-1:0] gain_d_ff;
   error_type prev_error_ff;

   logic rsp_valid_ff;
   speed_type left_ff, left_in;
   speed_type right_ff, right_in;
   error_type error_ff, error_in;
   mask_type mask_ff;

   logic signed [ERROR_W:0] diff;
   logic signed [CHG_W-1:0] change_full;
   logic signed [CHG_W-1:0] change_clamp;
   logic signed [SUM_W-1:0] change_sat;
   logic signed [SUM_W-1:0] left_sum;
   logic signed [SUM_W-1:0] right_sum;
   logic load;

   // line position pattern table
   function automatic error_type decode_error(input mask_type m, input error_type prior);
      error_type e;
      case (m)
         5'h01: e = -4'sd4;
         5'h03: e = -4'sd3;
         5'h02: e = -4'sd2;
         5'h06: e = -4'sd1;
         5'h04: e = 4'sd0;
         5'h0C: e = 4'sd1;
         5'h08: e = 4'sd2;
         5'h18: e = 4'sd3;
         5'h10: e = 4'sd4;
         5'h00: e = (prior > 0) ? ERR_LOST_POS : ERR_LOST_NEG;
         default: e = 4'sd0;
      endcase
      return e;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_p_ff <= GAIN_W'(GAIN_P_RESET);
         gain_d_ff <= GAIN_W'(GAIN_D_RESET);
      end else if (csr.write_en) begin
         case (csr.index)
            REG_GAIN_P: gain_p_ff <= csr.wdata[GAIN_W-1:0];
            REG_GAIN_D: gain_d_ff <= csr.wdata[GAIN_W-1:0];
            default: ;
         endcase
      end
   end

   assign load = head.valid && (!rsp_valid_ff || !rsp_stall);
   assign pop = load;

   always_comb begin
      error_in = decode_error(head.mask, prev_error_ff);
      diff = (ERROR_W + 1)'(error_in) - (ERROR_W + 1)'(prev_error_ff);
      change_full = CHG_W'($signed({1'b0, gain_p_ff})) * CHG_W'(error_in)
                  + CHG_W'($signed({1'b0, gain_d_ff})) * CHG_W'(diff);
      if (change_full > LIMIT_HI) begin
         change_clamp = LIMIT_HI;
      end else if (change_full < LIMIT_LO) begin
         change_clamp = LIMIT_LO;
      end else begin
         change_clamp = change_full;
      end
      change_sat = SUM_W'(change_clamp);
      left_sum = BASE_S + change_sat;
      right_sum = BASE_S - change_sat;
      if (error_in > 0) begin
         left_in = NEUTRAL_DUTY;
         right_in = right_sum[SPEED_W-1:0];
      end else if (error_in < 0) begin
         left_in = left_sum[SPEED_W-1:0];
         right_in = NEUTRAL_DUTY;
      end else begin
         left_in = NEUTRAL_DUTY;
         right_in = NEUTRAL_DUTY;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         prev_error_ff <= '0;
      end else begin
         if (load) begin
            rsp_valid_ff <= 1'b1;
            prev_error_ff <= error_in;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         left_ff <= left_in;
         right_ff <= right_in;
         error_ff <= error_in;
         mask_ff <= head.mask;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_left_speed = left_ff;
   assign rsp_right_speed = right_ff;
   assign rsp_line_error = error_ff;
   assign rsp_on_line_mask = mask_ff;

   `LSPD_ASSERT_HOLDS(a_error_range, rsp_valid_ff,
      (error_ff <= ERR_LOST_POS) && (error_ff >= ERR_LOST_NEG), "line error out of range")
   `LSPD_ASSERT_HOLDS(a_right_turn, rsp_valid_ff && (error_ff > 0),
      left_ff == NEUTRAL_DUTY, "left side not at base for positive error")
   `LSPD_ASSERT_HOLDS(a_left_turn, rsp_valid_ff && (error_ff < 0),
      right_ff == NEUTRAL_DUTY, "right side not at base for negative error")
   `LSPD_ASSERT_HOLDS(a_lost_line,
      rsp_valid_ff && ((error_ff == ERR_LOST_POS) || (error_ff == ERR_LOST_NEG)),
      mask_ff == '0, "lost-line error with sensors on line")
   `LSPD_ASSERT_NEXT(a_prev_tracks, load, prev_error_ff == error_ff,
      "previous error not tracking delivered error")

endmodule

FILE: sim/tb.sv
module tb;
   import lspd_pkg::*;

   localparam int SAMPLE_MAX = (1 << FIELD_W) - 1;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int SETTLE_CYCLES = 4;

   typedef logic [SENSOR_COUNT-1:0][FIELD_W-1:0] sample_set_type;

   typedef struct packed {
      speed_type left;
      speed_type right;
      error_type err;
      mask_type mask;
   } steer_type;

   // masks a real track produces: one or two adjacent sensors, or none when lost
   localparam mask_type TRACK_MASKS [10] = '{
      5'h01, 5'h03, 5'h02, 5'h06, 5'h04, 5'h0C, 5'h08, 5'h18, 5'h10, 5'h00
   };

   localparam logic [REG_INDEX_W-1:0] THR_REG [SENSOR_COUNT] = '{
      REG_THRESHOLD_0, REG_THRESHOLD_1, REG_THRESHOLD_2, REG_THRESHOLD_3, REG_THRESHOLD_4
   };

   // clock, reset and dut ports, the driven ones all known from time zero
   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write_en = 1'b0;
   logic [REG_INDEX_W-1:0] csr_index = '0;
   logic [CFG_DATA_W-1:0] csr_wdata = '0;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [FIELD_W-1:0] req_sample_0 = '0;
   logic [FIELD_W-1:0] req_sample_1 = '0;
   logic [FIELD_W-1:0] req_sample_2 = '0;
   logic [FIELD_W-1:0] req_sample_3 = '0;
   logic [FIELD_W-1:0] req_sample_4 = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [SPEED_W-1:0] rsp_left_speed;
   logic [SPEED_W-1:0] rsp_right_speed;
   logic signed [ERROR_W-1:0] rsp_line_error;
   logic [SENSOR_COUNT-1:0] rsp_on_line_mask;

   // predictor copy of the registers and the carried error
   logic [FIELD_W-1:0] thr [SENSOR_COUNT] = '{default: FIELD_W'(THRESHOLD_RESET)};
   logic white_floor = 1'b0;
   logic [GAIN_W-1:0] gain_p = GAIN_W'(GAIN_P_RESET);
   logic [GAIN_W-1:0] gain_d = GAIN_W'(GAIN_D_RESET);
   error_type held_error = '0;

   sample_set_type pending_sets [$];
   steer_type expected_steer [$];
   int mismatch_count = 0;

   // sender and receiver knobs, set per phase by the stimulus process
   int max_gap = 0;
   int stall_pct = 0;
   logic sender_pause = 1'b0;
   int hold_seq = 0;

   // sender state
   logic req_took = 1'b0;
   int burst_left = 1;
   int gap_left = 0;

   // receiver state
   int hold_seen = 0;
   int hold_left = 0;

   line_sensor_pd_steering dut (
      .clock(clock),
      .reset(reset),
      .csr_write_en(csr_write_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_sample_0(req_sample_0),
      .req_sample_1(req_sample_1),
      .req_sample_2(req_sample_2),
      .req_sample_3(req_sample_3),
      .req_sample_4(req_sample_4),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_left_speed(rsp_left_speed),
      .rsp_right_speed(rsp_right_speed),
      .rsp_line_error(rsp_line_error),
      .rsp_on_line_mask(rsp_on_line_mask)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // threshold compare, pattern decode and pd law; advances the carried error
   function automatic steer_type steer_for(sample_set_type s);
      steer_type r;
      mask_type m;
      int e;
      int change;
      int left;
      int right;
      m = '0;
      for (int i = 0; i < SENSOR_COUNT; i++) begin
         // a sample equal to its threshold is on the line in both modes
         if (white_floor ? (s[i] <= thr[i]) : (s[i] >= thr[i])) m[i] = 1'b1;
      end
      case (m)
         5'h01: e = -4;
         5'h03: e = -3;
         5'h02: e = -2;
         5'h06: e = -1;
         5'h04: e = 0;
         5'h0C: e = 1;
         5'h08: e = 2;
         5'h18: e = 3;
         5'h10: e = 4;
         // line lost: keep steering toward the side it was last seen
         5'h00: e = (held_error > 0) ? 5 : -5;
         default: e = 0;
      endcase
      change = int'(gain_p) * e + int'(gain_d) * (e - int'(held_error));
      if (change > CHANGE_LIMIT) change = CHANGE_LIMIT;
      else if (change < -CHANGE_LIMIT) change = -CHANGE_LIMIT;
      left = BASE_DUTY;
      right = BASE_DUTY;
      if (e > 0) right = BASE_DUTY - change;
      else if (e < 0) left = BASE_DUTY + change;
      r.left = speed_type'(left);
      r.right = speed_type'(right);
      r.err = error_type'(e);
      r.mask = m;
      held_error = r.err;
      return r;
   endfunction

   // samples that give the wanted mask under the current thresholds and floor, landing on
   // the threshold now and then; where a threshold leaves no off value the sensor is on
   function automatic sample_set_type samples_for_mask(mask_type m);
      sample_set_type s;
      int t;
      int v;
      for (int i = 0; i < SENSOR_COUNT; i++) begin
         t = int'(thr[i]);
         if (white_floor) begin
            if (m[i] || t == SAMPLE_MAX)
               v = ($urandom_range(0, 7) == 0) ? t : int'($urandom_range(0, t));
            else
               v = ($urandom_range(0, 7) == 0) ? t + 1 : int'($urandom_range(t + 1, SAMPLE_MAX));
         end else begin
            if (m[i] || t == 0)
               v = ($urandom_range(0, 7) == 0) ? t : int'($urandom_range(t, SAMPLE_MAX));
            else
               v = ($urandom_range(0, 7) == 0) ? t - 1 : int'($urandom_range(0, t - 1));
         end
         s[i] = FIELD_W'(v);
      end
      return s;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      mismatch_count++;
   endtask

   // one register write; the shadow copy follows at once since the block is idle
   task automatic write_reg(input logic [REG_INDEX_W-1:0] idx,
                            input logic [CFG_DATA_W-1:0] val);
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         REG_WHITE_BG: white_floor = val[0];
         REG_GAIN_P: gain_p = val[GAIN_W-1:0];
         REG_GAIN_D: gain_d = val[GAIN_W-1:0];
         default: thr[idx] = val[FIELD_W-1:0];
      endcase
   endtask

   // threshold style: 0 anywhere, 1 at or next to the rails, otherwise near mid-scale;
   // unused upper data bits carry junk
   task automatic configure(input int thr_style, input logic white,
                            input logic [GAIN_W-1:0] kp, input logic [GAIN_W-1:0] kd);
      logic [CFG_DATA_W-1:0] v;
      for (int i = 0; i < SENSOR_COUNT; i++) begin
         case (thr_style)
            0: v = CFG_DATA_W'($urandom_range(0, SAMPLE_MAX));
            1: begin
               case ($urandom_range(0, 3))
                  0: v = '0;
                  1: v = CFG_DATA_W'(1);
                  2: v = CFG_DATA_W'(SAMPLE_MAX - 1);
                  default: v = CFG_DATA_W'(SAMPLE_MAX);
               endcase
            end
            default: v = CFG_DATA_W'($urandom_range(1900, 2200));
         endcase
         write_reg(THR_REG[i], v);
      end
      write_reg(REG_WHITE_BG, {11'($urandom_range(0, 2047)), white});
      write_reg(REG_GAIN_P, {4'($urandom_range(0, 15)), kp});
      write_reg(REG_GAIN_D, {4'($urandom_range(0, 15)), kd});
      @(negedge clock);
      csr_write_en <= 1'b0;
   endtask

   // mostly sensible track masks with random content, the rest raw noise
   task automatic queue_random(input int count);
      sample_set_type s;
      for (int k = 0; k < count; k++) begin
         if ($urandom_range(0, 99) < 75) begin
            s = samples_for_mask(TRACK_MASKS[$urandom_range(0, 9)]);
         end else begin
            for (int i = 0; i < SENSOR_COUNT; i++) begin
               case ($urandom_range(0, 3))
                  0: s[i] = '0;
                  1: s[i] = FIELD_W'(SAMPLE_MAX);
                  default: s[i] = FIELD_W'($urandom_range(0, SAMPLE_MAX));
               endcase
            end
         end
         pending_sets.push_back(s);
      end
   endtask

   // checked on rising edges, where the sender's valid is stable
   task automatic wait_idle;
      while (pending_sets.size() != 0 || req_valid || expected_steer.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // sender: bursts of random length, random gaps, payload held while stalled
   always @(negedge clock) begin : feed_samples
      sample_set_type next_set;
      if (!req_valid || req_took) begin
         if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            req_valid <= 1'b0;
         end else if (!sender_pause && pending_sets.size() != 0) begin
            next_set = pending_sets.pop_front();
            req_sample_0 <= next_set[0];
            req_sample_1 <= next_set[1];
            req_sample_2 <= next_set[2];
            req_sample_3 <= next_set[3];
            req_sample_4 <= next_set[4];
            req_valid <= 1'b1;
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(1, 16);
               gap_left <= $urandom_range(0, max_gap);
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver: random stalls, plus a long hold whenever one is requested
   always @(negedge clock) begin
      if (hold_seen != hold_seq) begin
         hold_seen <= hold_seq;
         hold_left <= LONG_HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < stall_pct);
      end
   end

   // predict on every accepted sample item, check every accepted steering item
   always @(posedge clock) begin : check_steering
      sample_set_type seen;
      steer_type want;
      req_took <= !reset && req_valid && !req_stall;
      if (!reset && req_valid && !req_stall) begin
         seen = {req_sample_4, req_sample_3, req_sample_2, req_sample_1, req_sample_0};
         expected_steer.push_back(steer_for(seen));
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_steer.size() == 0) begin
            report_mismatch("steering item with nothing expected");
         end else begin
            want = expected_steer.pop_front();
            if (rsp_left_speed !== want.left)
               report_mismatch($sformatf("left_speed got %0d want %0d",
                                         rsp_left_speed, want.left));
            if (rsp_right_speed !== want.right)
               report_mismatch($sformatf("right_speed got %0d want %0d",
                                         rsp_right_speed, want.right));
            if (rsp_line_error !== want.err)
               report_mismatch($sformatf("line_error got %0d want %0d",
                                         rsp_line_error, want.err));
            if (rsp_on_line_mask !== want.mask)
               report_mismatch($sformatf("on_line_mask got %b want %b",
                                         rsp_on_line_mask, want.mask));
         end
      end
   end

   initial begin : stimulus
      sample_set_type s;
      repeat (10) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // directed items under reset settings: black floor, mid thresholds, gains 40
      max_gap = 2;
      stall_pct = 25;
      pending_sets.push_back('1);                 // all on: unlisted pattern
      pending_sets.push_back('0);                 // lost with no history
      pending_sets.push_back({SENSOR_COUNT{FIELD_W'(THRESHOLD_RESET)}});  // all at threshold
      foreach (TRACK_MASKS[k]) pending_sets.push_back(samples_for_mask(TRACK_MASKS[k]));
      pending_sets.push_back(samples_for_mask(5'h00));   // lost again, stays positive
      pending_sets.push_back(samples_for_mask(5'h01));
      pending_sets.push_back(samples_for_mask(5'h00));   // lost to the left
      pending_sets.push_back(samples_for_mask(5'h05));
      pending_sets.push_back(samples_for_mask(5'h11));
      pending_sets.push_back(samples_for_mask(5'h1F));
      // centre exactly on its threshold, the rest one below
      s = {SENSOR_COUNT{FIELD_W'(THRESHOLD_RESET - 1)}};
      s[2] = FIELD_W'(THRESHOLD_RESET);
      pending_sets.push_back(s);
      wait_idle;

      // black floor, back-to-back with no idling on either side
      configure(0, 1'b0, 8'd40, 8'd40);
      max_gap = 0;
      stall_pct = 0;
      queue_random(200);
      wait_idle;

      // white floor, thresholds at or next to the rails, gains maxed; long receiver hold
      configure(1, 1'b1, 8'd255, 8'd255);
      max_gap = 4;
      stall_pct = 30;
      queue_random(200);
      hold_seq++;
      wait_idle;

      // zero gains: speeds never leave base
      configure(0, 1'b0, 8'd0, 8'd0);
      max_gap = 8;
      stall_pct = 60;
      queue_random(150);
      wait_idle;

      // white floor, random gains; sender pauses mid-stream until drained
      configure(0, 1'b1, GAIN_W'($urandom_range(0, 255)), GAIN_W'($urandom_range(0, 255)));
      max_gap = 3;
      stall_pct = 20;
      queue_random(250);
      while (pending_sets.size() > 125) @(posedge clock);
      sender_pause = 1'b1;
      while (req_valid || expected_steer.size() != 0) @(posedge clock);
      sender_pause = 1'b0;
      wait_idle;

      // near mid-scale thresholds, tiny p and large d; long hold mid-stream
      configure(2, 1'b0, 8'd1, 8'd255);
      max_gap = 2;
      stall_pct = 50;
      queue_random(200);
      while (pending_sets.size() > 100) @(posedge clock);
      hold_seq++;
      wait_idle;

      // white floor, p only
      configure(0, 1'b1, GAIN_W'($urandom_range(0, 255)), 8'd0);
      max_gap = 6;
      stall_pct = 10;
      queue_random(200);
      wait_idle;

      repeat (10) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   // hang guard, far beyond the slowest correct run
   initial begin
      #3200000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule
